[hdl/utf8_dec_pkg.sv]
`default_nettype none

package utf8_dec_pkg;

   // Field widths
   localparam int CP_W   = 21;
   localparam int BYTE_W = 8;

   // Replacement code point after reset: a space
   localparam logic [CP_W-1:0] REPL_RESET = CP_W'(32);

   // Byte class boundaries
   localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_MIN  = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

   // Continuation counts started by each lead byte
   localparam logic [1:0] PEND_NONE  = 2'd0;
   localparam logic [1:0] PEND_LEAD2 = 2'd1;
   localparam logic [1:0] PEND_LEAD3 = 2'd2;
   localparam logic [1:0] PEND_LEAD4 = 2'd3;

   // Default result queue depth, as log2
   localparam int RSP_DEPTH_LOG2_DEF = 2;

   // One result item
   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_error;
      logic            last_of_run;
   } result_type;

endpackage

`default_nettype wire

[hdl/utf8_stream_decoder.sv]
// Lenient UTF-8 stream decoder.
// Request channel: req_valid / req_stall carry one byte (req_in_byte) and a flag
// (req_end_of_string) that marks the last byte of a string. A byte is taken at
// a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall carry decoded code points, each with
// an error flag (replacement for malformed input) and a flag on the last result
// that one byte caused. A byte gives zero, one or two results.
// Configuration: csr_wr_en with csr_wr_data sets the replacement code point;
// write only while no request is in flight.
// Throughput: one byte per cycle while req_stall is low. The decode is a single pass over the byte and
// the accumulator; results go to a small result queue (4 entries by default).
// A byte giving two results is handed out as two separate responses.
// A result is registered into the queue when its byte is taken; rsp_valid comes from the registered fill count.
// req_stall rises while fewer than two queue entries are free, so a stalled
// receiver backs up the request side after the queue fills.
// Reset (synchronous, active high) empties the queue, clears the accumulator
// and pending count and sets the replacement code point to a space.
`default_nettype none

module utf8_stream_decoder #(
   parameter int RSP_DEPTH_LOG2 = utf8_dec_pkg::RSP_DEPTH_LOG2_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [utf8_dec_pkg::BYTE_W-1:0] req_in_byte,
   input  wire logic                         req_end_of_string,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [utf8_dec_pkg::CP_W-1:0]     rsp_code_point,
   output logic                              rsp_is_error,
   output logic                              rsp_last_of_run,
   input  wire logic                         csr_wr_en,
   input  wire logic [utf8_dec_pkg::CP_W-1:0] csr_wr_data
);
   import utf8_dec_pkg::*;

   localparam int PTR_W     = RSP_DEPTH_LOG2;
   localparam int CNT_W     = RSP_DEPTH_LOG2 + 1;
   localparam int RSP_DEPTH = 1 << RSP_DEPTH_LOG2;

   logic [CP_W-1:0]  repl_ff;
   logic [CP_W-1:0]  acc_ff, acc_in;
   logic [1:0]       pend_ff, pend_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   result_type       mem_ff [RSP_DEPTH];

   result_type       res [2];
   logic [1:0]       res_n;
   logic [1:0]       pend_dec;
   logic [CP_W-1:0]  acc_shift;
   logic             req_take;
   logic             rsp_take;

   // Hold the replacement code point
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign pend_dec  = pend_ff - 2'd1;
   assign acc_shift = {acc_ff[CP_W-7:0], req_in_byte[5:0]};

   // Decode one byte against the pending sequence
   always_comb begin
      acc_in  = acc_ff;
      pend_in = pend_ff;
      res_n   = 2'd0;
      res[0]  = '{code_point: repl_ff, is_error: 1'b1, last_of_run: 1'b0};
      res[1]  = '{code_point: repl_ff, is_error: 1'b1, last_of_run: 1'b0};

      unique case (req_in_byte) inside
         [8'h00:ASCII_MAX]: begin
            if (pend_ff != PEND_NONE) begin
               res[1] = '{code_point: CP_W'(req_in_byte), is_error: 1'b0,
                          last_of_run: 1'b0};
               res_n  = 2'd2;
            end else begin
               res[0] = '{code_point: CP_W'(req_in_byte), is_error: 1'b0,
                          last_of_run: 1'b0};
               res_n  = 2'd1;
            end
            pend_in = PEND_NONE;
         end
         [CONT_MIN:CONT_MAX]: begin
            if (pend_ff != PEND_NONE) begin
               acc_in  = acc_shift;
               pend_in = pend_dec;
               if (pend_dec == PEND_NONE) begin
                  res[0] = '{code_point: acc_shift, is_error: 1'b0, last_of_run: 1'b0};
                  res_n  = 2'd1;
               end
            end else begin
               res_n = 2'd1;
            end
         end
         [LEAD2_MIN:LEAD2_MAX]: begin
            pend_in = PEND_LEAD2;
            acc_in  = CP_W'(req_in_byte[4:0]);
         end
         [LEAD3_MIN:LEAD3_MAX]: begin
            pend_in = PEND_LEAD3;
            acc_in  = CP_W'(req_in_byte[3:0]);
         end
         [LEAD4_MIN:LEAD4_MAX]: begin
            pend_in = PEND_LEAD4;
            acc_in  = CP_W'(req_in_byte[2:0]);
         end
         default: begin
            res_n   = 2'd1;
            pend_in = PEND_NONE;
         end
      endcase

      // Flush an unfinished sequence at end of string
      if (req_end_of_string) begin
         if (pend_in != PEND_NONE) begin
            res_n = res_n + 2'd1;
         end
         pend_in = PEND_NONE;
         acc_in  = '0;
      end

      // Mark the final result of this byte
      if (res_n == 2'd1) begin
         res[0].last_of_run = 1'b1;
      end else if (res_n == 2'd2) begin
         res[1].last_of_run = 1'b1;
      end
   end

   // Advance decode state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= PEND_NONE;
      end else if (req_take) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

   // Result queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(res_n);
         count_in  = count_in + CNT_W'(res_n);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write up to two results per request
   always_ff @(posedge clock) begin
      if (req_take) begin
         if (res_n != 2'd0) begin
            mem_ff[wr_ptr_ff] <= res[0];
         end
         if (res_n == 2'd2) begin
            mem_ff[wr_ptr_ff + PTR_W'(1)] <= res[1];
         end
      end
   end

   // Stall requests while fewer than two entries are free
   assign req_stall       = count_ff > CNT_W'(RSP_DEPTH - 2);
   assign rsp_valid       = count_ff != '0;
   assign rsp_code_point  = mem_ff[rd_ptr_ff].code_point;
   assign rsp_is_error    = mem_ff[rd_ptr_ff].is_error;
   assign rsp_last_of_run = mem_ff[rd_ptr_ff].last_of_run;

   // Queue never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // End of string leaves no pending sequence
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_end_of_string |=> pend_ff == PEND_NONE && acc_ff == '0)
      else $error("state not cleared at end of string");

   // An ASCII byte drops any pending sequence
   a_ascii_drops: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_in_byte[7] |=> pend_ff == PEND_NONE)
      else $error("sequence kept across ASCII byte");

   // A taken request that yields results makes the queue non-empty
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      req_take && res_n != 2'd0 |=> rsp_valid)
      else $error("result lost from queue");

endmodule

`default_nettype wire
